// ----- rtl/word_frequency_table_macros.svh -----
// Assertion macros for the word frequency table RTL.
// Included by the modules that carry concurrent assertions.
`ifndef WORD_FREQUENCY_TABLE_MACROS_SVH
`define WORD_FREQUENCY_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WFT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define WFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/wft_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers of the word frequency table.
// No dependencies; used by wft_cell and word_frequency_table.
package wft_pkg;

  localparam int TABLE_DEPTH    = 32;
  localparam int MAX_WORD_CHARS = 14;
  localparam int COUNT_WIDTH    = 32;
  localparam int SLOT_W         = 5;
  localparam int USED_W         = 6;
  localparam int LEN_W          = 4;
  localparam int LOW_W          = 64;
  localparam int HIGH_W         = 48;
  localparam int OUT_COUNT_W    = 32;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REPORT = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE,
    ST_REPORT
  } state_t;

  typedef struct packed {
    command_t           command;
    logic [LOW_W-1:0]   word_low;
    logic [HIGH_W-1:0]  word_high;
    logic [LEN_W-1:0]   word_length;
  } request_t;

  typedef struct packed {
    logic [SLOT_W-1:0]      slot;
    logic [LOW_W-1:0]       entry_low;
    logic [HIGH_W-1:0]      entry_high;
    logic [LEN_W-1:0]       entry_length;
    logic [OUT_COUNT_W-1:0] count;
    logic                   is_new;
    logic                   dropped;
    logic [SLOT_W-1:0]      longest_slot;
    logic [SLOT_W-1:0]      shortest_slot;
    logic [SLOT_W-1:0]      most_slot;
    logic [USED_W-1:0]      entries_used;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic [LOW_W-1:0]  lo;
    logic [HIGH_W-1:0] hi;
    logic [LEN_W-1:0]  len;
  } word_t;

  typedef struct packed {
    word_t                  word;
    logic [COUNT_WIDTH-1:0] count;
  } entry_t;

  typedef struct packed {
    logic match_en;
    logic shift;
    logic load;
    logic bump;
  } cell_ctrl_t;

  // Clamp the length and zero every byte at or beyond it.
  function automatic word_t mask_word(request_t req);
    word_t             w;
    logic [LEN_W-1:0]  len_c;
    if (req.word_length > LEN_W'(MAX_WORD_CHARS)) begin
      len_c = LEN_W'(MAX_WORD_CHARS);
    end else begin
      len_c = req.word_length;
    end
    w.len = len_c;
    for (int b = 0; b < LOW_W / 8; b++) begin
      w.lo[8*b +: 8] = (b < int'(len_c)) ? req.word_low[8*b +: 8] : 8'h00;
    end
    for (int b = 0; b < HIGH_W / 8; b++) begin
      w.hi[8*b +: 8] = (b + LOW_W / 8 < int'(len_c)) ? req.word_high[8*b +: 8] : 8'h00;
    end
    return w;
  endfunction

endpackage

// ----- rtl/wft_cell.sv -----
`timescale 1ns / 1ps
// One table slot: stored word, its count and the match against the broadcast word.
// Depends on wft_pkg; chained into a ring by word_frequency_table.
module wft_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  wft_pkg::cell_ctrl_t             ctrl,
  input  wft_pkg::word_t                  probe,
  input  logic [wft_pkg::COUNT_WIDTH-1:0] bump_count,
  input  wft_pkg::entry_t                 from_next,
  output wft_pkg::entry_t                 entry,
  output logic                            hit
);

  wft_pkg::word_t                  word;
  logic [wft_pkg::COUNT_WIDTH-1:0] count;

  // Word payload: rotate on report, take the probe on insert.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      word <= from_next.word;
    end else if (ctrl.load) begin
      word <= probe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.shift) begin
      count <= from_next.count;
    end else if (ctrl.load) begin
      count <= wft_pkg::COUNT_WIDTH'(1);
    end else if (ctrl.bump) begin
      count <= bump_count;
    end
  end

  assign entry.word  = word;
  assign entry.count = count;
  assign hit = ctrl.match_en && (word.len == probe.len) &&
               (word.lo == probe.lo) && (word.hi == probe.hi);

endmodule

// ----- rtl/word_frequency_table.sv -----
`timescale 1ns / 1ps
// Word frequency table top level: control sequencer and a ring of wft_cell slots.
// Depends on wft_pkg, wft_cell and word_frequency_table_macros.svh.
//
// Usage:
//   Raise start with a request while busy is low; the request is taken at that edge.
//   An add request (command 0) is masked to its length, compared against every
//   occupied slot at once, then counted up, inserted or dropped. busy stays high
//   through the match and update states; the single result appears with strobe
//   once busy is low again, and a new request may be taken in that same cycle.
//   A report request (command 1) rotates the slot ring once through slot 0, one
//   step per cycle: busy stays high until the ring has turned full circle, and one
//   result per occupied slot appears on consecutive cycles, in slot order, with
//   last on the final one. An empty table gives one all-zero result with last set
//   and leaves the report state at once.
//   The ring rotation sets the report length; the compare, then update steps set
//   the add length.
//   Each result is valid for exactly one cycle with strobe; the receiver cannot
//   stall. Synchronous reset empties the table, clears counts and trackers.
`include "word_frequency_table_macros.svh"

module word_frequency_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  wft_pkg::request_t request,
  output logic              strobe,
  output wft_pkg::result_t  result
);

  localparam int DEPTH = wft_pkg::TABLE_DEPTH;
  localparam int SW    = wft_pkg::SLOT_W;
  localparam int UW    = wft_pkg::USED_W;
  localparam int CW    = wft_pkg::COUNT_WIDTH;

  wft_pkg::state_t state, state_next;

  wft_pkg::word_t       probe;
  logic [UW-1:0]        used, used_next;
  logic [SW-1:0]        longest, longest_next;
  logic [SW-1:0]        shortest, shortest_next;
  logic [SW-1:0]        most, most_next;
  logic [wft_pkg::LEN_W-1:0] longest_len, longest_len_next;
  logic [wft_pkg::LEN_W-1:0] shortest_len, shortest_len_next;
  logic [CW-1:0]        most_cnt, most_cnt_next;
  logic [SW-1:0]        step, step_next;

  logic [DEPTH-1:0]     hit_now;
  logic [DEPTH-1:0]     hit_vec;
  logic                 hit_any;
  logic [SW-1:0]        hit_idx, hit_idx_now;
  logic [CW-1:0]        hit_cnt, hit_cnt_now;
  logic [CW-1:0]        new_cnt;

  logic                 emit;
  wft_pkg::result_t     result_next;
  logic                 do_insert;
  logic                 do_shift;
  logic [DEPTH-1:0]     load_vec;

  wft_pkg::entry_t      ent  [DEPTH];
  wft_pkg::cell_ctrl_t  ctrl [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int NXT = (i + 1) % DEPTH;
    always_comb begin
      ctrl[i].match_en = (UW'(i) < used);
      ctrl[i].shift    = do_shift;
      ctrl[i].load     = load_vec[i];
      ctrl[i].bump     = (state == wft_pkg::ST_UPDATE) && hit_vec[i];
    end
    wft_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl[i]),
      .probe      (probe),
      .bump_count (new_cnt),
      .from_next  (ent[NXT]),
      .entry      (ent[i]),
      .hit        (hit_now[i])
    );
  end

  // Encode the (at most one-hot) hit vector and pick the hit count.
  always_comb begin
    hit_idx_now = '0;
    hit_cnt_now = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_idx_now = hit_idx_now | (hit_now[i] ? SW'(i) : '0);
      hit_cnt_now = hit_cnt_now | (hit_now[i] ? ent[i].count : '0);
    end
  end

  assign new_cnt   = (hit_cnt == wft_pkg::COUNT_MAX) ? hit_cnt : hit_cnt + CW'(1);
  assign do_insert = !hit_any && (used < UW'(DEPTH));
  assign do_shift  = (state == wft_pkg::ST_REPORT) && (used != '0);
  assign busy      = (state != wft_pkg::ST_IDLE);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      load_vec[i] = (state == wft_pkg::ST_UPDATE) && do_insert && (used == UW'(i));
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      wft_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (request.command == wft_pkg::CMD_REPORT) ?
                       wft_pkg::ST_REPORT : wft_pkg::ST_MATCH;
        end
      end
      wft_pkg::ST_MATCH:  state_next = wft_pkg::ST_UPDATE;
      wft_pkg::ST_UPDATE: state_next = wft_pkg::ST_IDLE;
      wft_pkg::ST_REPORT: begin
        if ((used == '0) || (step == SW'(DEPTH - 1))) begin
          state_next = wft_pkg::ST_IDLE;
        end
      end
      default: state_next = wft_pkg::ST_IDLE;
    endcase
  end

  // Outputs and tracker updates.
  always_comb begin
    emit              = 1'b0;
    result_next       = '0;
    used_next         = used;
    longest_next      = longest;
    shortest_next     = shortest;
    most_next         = most;
    longest_len_next  = longest_len;
    shortest_len_next = shortest_len;
    most_cnt_next     = most_cnt;
    step_next         = step;
    case (state)
      wft_pkg::ST_IDLE: begin
        step_next = '0;
      end
      wft_pkg::ST_MATCH: begin
      end
      wft_pkg::ST_UPDATE: begin
        emit = 1'b1;
        if (hit_any) begin
          if ((new_cnt > most_cnt) || ((new_cnt == most_cnt) && (hit_idx < most))) begin
            most_next     = hit_idx;
            most_cnt_next = new_cnt;
          end
        end else if (do_insert) begin
          used_next = used + UW'(1);
          if (used == '0) begin
            longest_next      = '0;
            shortest_next     = '0;
            most_next         = '0;
            longest_len_next  = probe.len;
            shortest_len_next = probe.len;
            most_cnt_next     = CW'(1);
          end else begin
            if (probe.len > longest_len) begin
              longest_next     = used[SW-1:0];
              longest_len_next = probe.len;
            end
            if (probe.len < shortest_len) begin
              shortest_next     = used[SW-1:0];
              shortest_len_next = probe.len;
            end
          end
        end
        result_next.entry_low     = probe.lo;
        result_next.entry_high    = probe.hi;
        result_next.entry_length  = probe.len;
        result_next.is_new        = !hit_any && do_insert;
        result_next.dropped       = !hit_any && !do_insert;
        if (hit_any) begin
          result_next.slot  = hit_idx;
          result_next.count = wft_pkg::OUT_COUNT_W'(new_cnt);
        end else if (do_insert) begin
          result_next.slot  = used[SW-1:0];
          result_next.count = wft_pkg::OUT_COUNT_W'(1);
        end
        result_next.longest_slot  = longest_next;
        result_next.shortest_slot = shortest_next;
        result_next.most_slot     = most_next;
        result_next.entries_used  = used_next;
        result_next.last          = 1'b1;
      end
      wft_pkg::ST_REPORT: begin
        step_next = step + SW'(1);
        if (used == '0) begin
          emit             = 1'b1;
          result_next.last = 1'b1;
        end else if ({1'b0, step} < used) begin
          // Slot 0 of the ring holds the slot numbered by step.
          emit                      = 1'b1;
          result_next.slot          = step;
          result_next.entry_low     = ent[0].word.lo;
          result_next.entry_high    = ent[0].word.hi;
          result_next.entry_length  = ent[0].word.len;
          result_next.count         = wft_pkg::OUT_COUNT_W'(ent[0].count);
          result_next.longest_slot  = longest;
          result_next.shortest_slot = shortest;
          result_next.most_slot     = most;
          result_next.entries_used  = used;
          result_next.last          = (({1'b0, step} + UW'(1)) == used);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= wft_pkg::ST_IDLE;
      used         <= '0;
      longest      <= '0;
      shortest     <= '0;
      most         <= '0;
      longest_len  <= '0;
      shortest_len <= '0;
      most_cnt     <= '0;
      step         <= '0;
      strobe       <= 1'b0;
    end else begin
      state        <= state_next;
      used         <= used_next;
      longest      <= longest_next;
      shortest     <= shortest_next;
      most         <= most_next;
      longest_len  <= longest_len_next;
      shortest_len <= shortest_len_next;
      most_cnt     <= most_cnt_next;
      step         <= step_next;
      strobe       <= emit;
    end
  end

  // Payload: masked request word, match capture, result register.
  always_ff @(posedge clk) begin
    if ((state == wft_pkg::ST_IDLE) && start) begin
      probe <= wft_pkg::mask_word(request);
    end
    if (state == wft_pkg::ST_MATCH) begin
      hit_vec <= hit_now;
      hit_any <= |hit_now;
      hit_idx <= hit_idx_now;
      hit_cnt <= hit_cnt_now;
    end
    if (emit) begin
      result <= result_next;
    end
  end

  `WFT_ASSERT_NOW(a_hit_unique, clk, rst, state == wft_pkg::ST_MATCH, $onehot0(hit_now),
    "stored words are not unique")
  `WFT_ASSERT_NOW(a_load_single, clk, rst, 1'b1, $onehot0(load_vec),
    "more than one slot loaded")
  `WFT_ASSERT_NOW(a_used_bound, clk, rst, 1'b1, used <= UW'(DEPTH),
    "occupied count exceeds table depth")
  `WFT_ASSERT_NEXT(a_insert_grows, clk, rst,
    (state == wft_pkg::ST_UPDATE) && !hit_any && (used < UW'(DEPTH)),
    used == $past(used) + UW'(1), "insert did not grow the table")
  `WFT_ASSERT_NEXT(a_report_burst, clk, rst, strobe && !result.last, strobe,
    "report results not contiguous")

endmodule

// ----- sim/word_frequency_table_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for word_frequency_table: add and report requests
// are checked against a table model kept alongside. Depends on wft_pkg.
module word_frequency_table_tb;

  localparam int VOCAB_SIZE  = 44;
  localparam int RANDOM_REQS = 190;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 200000;

  localparam int LOW_W  = wft_pkg::LOW_W;
  localparam int HIGH_W = wft_pkg::HIGH_W;
  localparam int LEN_W  = wft_pkg::LEN_W;
  localparam int CW     = wft_pkg::COUNT_WIDTH;
  localparam int SW     = wft_pkg::SLOT_W;

  typedef struct packed {
    wft_pkg::request_t req;
    logic              drain;
  } pending_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              start = 1'b0;
  logic              busy;
  wft_pkg::request_t request = '0;
  logic              strobe;
  wft_pkg::result_t  result;

  word_frequency_table uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
  );

  always #4 clk = ~clk;

  // Table model
  logic [LOW_W-1:0]  tbl_lo  [wft_pkg::TABLE_DEPTH];
  logic [HIGH_W-1:0] tbl_hi  [wft_pkg::TABLE_DEPTH];
  logic [LEN_W-1:0]  tbl_len [wft_pkg::TABLE_DEPTH];
  logic [CW-1:0]     tbl_cnt [wft_pkg::TABLE_DEPTH];
  int                words_held = 0;
  logic [SW-1:0]     longest_at = '0;
  logic [SW-1:0]     shortest_at = '0;
  logic [SW-1:0]     most_at = '0;

  wft_pkg::result_t expected_results[$];
  pending_t         pending_requests[$];
  int               n_issued = 0;
  int               n_accepted = 0;
  int               errors = 0;
  int               cycles = 0;
  int               gap_left = 0;
  int               streak_left = 0;
  int               roll;
  pending_t         next_req;

  // Vocabulary for random adds
  logic [LOW_W-1:0]  voc_lo  [VOCAB_SIZE];
  logic [HIGH_W-1:0] voc_hi  [VOCAB_SIZE];
  logic [LEN_W-1:0]  voc_len [VOCAB_SIZE];

  function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] len);
    return (len > LEN_W'(wft_pkg::MAX_WORD_CHARS)) ? LEN_W'(wft_pkg::MAX_WORD_CHARS) : len;
  endfunction

  // Byte mask over {high, low} covering the characters inside the word.
  function automatic logic [HIGH_W+LOW_W-1:0] char_mask(logic [LEN_W-1:0] len);
    logic [HIGH_W+LOW_W-1:0] m;
    m = '0;
    for (int b = 0; b < wft_pkg::MAX_WORD_CHARS; b++) begin
      if (b < int'(clamp_len(len))) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic wft_pkg::result_t table_result(int slot, logic [LOW_W-1:0] lo,
                                                    logic [HIGH_W-1:0] hi,
                                                    logic [LEN_W-1:0] len,
                                                    logic [CW-1:0] cnt,
                                                    logic fresh, logic lost, logic fin);
    wft_pkg::result_t r;
    r.slot          = SW'(slot);
    r.entry_low     = lo;
    r.entry_high    = hi;
    r.entry_length  = len;
    r.count         = wft_pkg::OUT_COUNT_W'(cnt);
    r.is_new        = fresh;
    r.dropped       = lost;
    r.longest_slot  = longest_at;
    r.shortest_slot = shortest_at;
    r.most_slot     = most_at;
    r.entries_used  = wft_pkg::USED_W'(words_held);
    r.last          = fin;
    return r;
  endfunction

  task automatic tally_request(wft_pkg::request_t req);
    wft_pkg::result_t        r;
    logic [HIGH_W+LOW_W-1:0] w;
    logic [LOW_W-1:0]        lo;
    logic [HIGH_W-1:0]       hi;
    logic [LEN_W-1:0]        len;
    int                      hit;
    if (req.command == wft_pkg::CMD_REPORT) begin
      if (words_held == 0) begin
        r = '0;
        r.last = 1'b1;
        expected_results.push_back(r);
      end else begin
        for (int i = 0; i < words_held; i++) begin
          expected_results.push_back(table_result(i, tbl_lo[i], tbl_hi[i], tbl_len[i],
                                                  tbl_cnt[i], 1'b0, 1'b0,
                                                  i == words_held - 1));
        end
      end
    end else begin
      len = clamp_len(req.word_length);
      w   = {req.word_high, req.word_low} & char_mask(req.word_length);
      lo  = w[LOW_W-1:0];
      hi  = w[HIGH_W+LOW_W-1:LOW_W];
      hit = -1;
      for (int i = 0; i < words_held; i++) begin
        if (hit < 0 && tbl_len[i] == len && tbl_lo[i] == lo && tbl_hi[i] == hi) hit = i;
      end
      if (hit >= 0) begin
        if (tbl_cnt[hit] != wft_pkg::COUNT_MAX) tbl_cnt[hit]++;
        if (tbl_cnt[hit] > tbl_cnt[most_at] ||
            (tbl_cnt[hit] == tbl_cnt[most_at] && hit < int'(most_at))) begin
          most_at = SW'(hit);
        end
        r = table_result(hit, lo, hi, len, tbl_cnt[hit], 1'b0, 1'b0, 1'b1);
      end else if (words_held >= wft_pkg::TABLE_DEPTH) begin
        r = table_result(0, lo, hi, len, '0, 1'b0, 1'b1, 1'b1);
      end else begin
        tbl_lo[words_held]  = lo;
        tbl_hi[words_held]  = hi;
        tbl_len[words_held] = len;
        tbl_cnt[words_held] = CW'(1);
        if (words_held == 0) begin
          longest_at  = '0;
          shortest_at = '0;
          most_at     = '0;
        end else begin
          if (len > tbl_len[longest_at]) longest_at = SW'(words_held);
          if (len < tbl_len[shortest_at]) shortest_at = SW'(words_held);
        end
        words_held++;
        r = table_result(words_held - 1, lo, hi, len, CW'(1), 1'b1, 1'b0, 1'b1);
      end
      expected_results.push_back(r);
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic queue_request(wft_pkg::command_t cmd, logic [LOW_W-1:0] lo,
                               logic [HIGH_W-1:0] hi, logic [LEN_W-1:0] len,
                               logic drain);
    pending_t p;
    p.req.command     = cmd;
    p.req.word_low    = lo;
    p.req.word_high   = hi;
    p.req.word_length = len;
    p.drain           = drain;
    pending_requests.push_back(p);
  endtask

  // Driver: raise start with the next request, hold it until taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && n_accepted != n_issued) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      start <= 1'b0;
    end else if (pending_requests.size() == 0) begin
      start <= 1'b0;
    end else if (pending_requests[0].drain && expected_results.size() != 0) begin
      // hold off until every result of earlier requests is back
      start <= 1'b0;
    end else begin
      next_req = pending_requests.pop_front();
      request <= next_req.req;
      start   <= 1'b1;
      n_issued++;
      roll = int'($urandom_range(0, 99));
      if (streak_left > 0) begin
        streak_left--;
        gap_left = 0;
      end else if (roll < 8) begin
        streak_left = int'($urandom_range(8, 20));
        gap_left = 0;
      end else if (roll < 50) begin
        gap_left = 0;
      end else if (roll < 90) begin
        gap_left = int'($urandom_range(1, 3));
      end else begin
        gap_left = int'($urandom_range(6, 40));
      end
    end
  end

  // Monitor: check each strobed result, then account for a taken request.
  always @(posedge clk) begin
    wft_pkg::result_t want;
    if (!rst) begin
      if (strobe === 1'b1) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, result);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("slot", want.slot, result.slot);
          check_field("entry_low", want.entry_low, result.entry_low);
          check_field("entry_high", want.entry_high, result.entry_high);
          check_field("entry_length", want.entry_length, result.entry_length);
          check_field("count", want.count, result.count);
          check_field("is_new", want.is_new, result.is_new);
          check_field("dropped", want.dropped, result.dropped);
          check_field("longest_slot", want.longest_slot, result.longest_slot);
          check_field("shortest_slot", want.shortest_slot, result.shortest_slot);
          check_field("most_slot", want.most_slot, result.most_slot);
          check_field("entries_used", want.entries_used, result.entries_used);
          check_field("last", want.last, result.last);
        end
      end
      if (start && !busy) begin
        tally_request(request);
        n_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL word_frequency_table");
      $finish;
    end
  end

  initial begin
    logic [HIGH_W+LOW_W-1:0] word;
    logic [HIGH_W+LOW_W-1:0] keep;
    logic [127:0]            noise;
    logic [LEN_W-1:0]        len;
    int                      v;
    rst = 1'b1;

    // Directed: empty report, empty word, clamped length, stray bytes,
    // zero characters inside the word, length boundaries, repeats.
    queue_request(wft_pkg::CMD_REPORT, '0, '0, '0, 1'b0);
    queue_request(wft_pkg::CMD_ADD, '1, '1, 4'd0, 1'b0);
    queue_request(wft_pkg::CMD_ADD, '0, '0, 4'd0, 1'b0);
    queue_request(wft_pkg::CMD_ADD, '1, '1, 4'd15, 1'b0);
    queue_request(wft_pkg::CMD_ADD, '1, '1, 4'd14, 1'b0);
    queue_request(wft_pkg::CMD_ADD, '0, '0, 4'd3, 1'b0);
    queue_request(wft_pkg::CMD_ADD, '1, '1, 4'd1, 1'b0);
    queue_request(wft_pkg::CMD_ADD, 64'h0000_0000_0000_00FF, '0, 4'd1, 1'b0);
    queue_request(wft_pkg::CMD_ADD, 64'h8000_0000_0000_0001, '1, 4'd8, 1'b0);
    queue_request(wft_pkg::CMD_ADD, 64'h8000_0000_0000_0001, 48'h0000_0000_0001, 4'd9,
                  1'b0);
    queue_request(wft_pkg::CMD_ADD, 64'h7766_5544_3322_1100, 48'hFFCC_BBAA_9988, 4'd13,
                  1'b0);
    queue_request(wft_pkg::CMD_ADD, 64'h0A0B_0C0D_0E0F_1011, '0, 4'd7, 1'b0);
    queue_request(wft_pkg::CMD_ADD, '1, '1, 4'd1, 1'b0);
    queue_request(wft_pkg::CMD_ADD, '1, '1, 4'd1, 1'b0);
    queue_request(wft_pkg::CMD_ADD, 64'h0, 48'h0, 4'd0, 1'b0);
    queue_request(wft_pkg::CMD_ADD, 64'h8000_0000_0000_0001, 48'h5500_0000_0001, 4'd9,
                  1'b0);
    queue_request(wft_pkg::CMD_REPORT, '1, '1, 4'd15, 1'b0);

    for (int i = 0; i < VOCAB_SIZE; i++) begin
      voc_lo[i]  = {$urandom, $urandom};
      voc_hi[i]  = HIGH_W'({$urandom, $urandom});
      voc_len[i] = LEN_W'($urandom_range(0, 15));
    end

    for (int n = 0; n < RANDOM_REQS; n++) begin
      roll = int'($urandom_range(0, 99));
      if (roll < 8) begin
        queue_request(wft_pkg::CMD_REPORT, {$urandom, $urandom},
                      HIGH_W'({$urandom, $urandom}), LEN_W'($urandom_range(0, 15)),
                      $urandom_range(0, 9) == 0);
      end else if (roll < 20) begin
        queue_request(wft_pkg::CMD_ADD, {$urandom, $urandom},
                      HIGH_W'({$urandom, $urandom}), LEN_W'($urandom_range(0, 15)),
                      $urandom_range(0, 29) == 0);
      end else begin
        // favor a core of words so most adds hit; the rest spills past a full table
        v = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, VOCAB_SIZE - 1))
                                        : int'($urandom_range(0, 15));
        len = voc_len[v];
        if (len >= LEN_W'(wft_pkg::MAX_WORD_CHARS)) begin
          len = LEN_W'($urandom_range(wft_pkg::MAX_WORD_CHARS, 15));
        end
        word  = {voc_hi[v], voc_lo[v]};
        keep  = char_mask(len);
        noise = {$urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 1) == 1) begin
          word = (word & keep) | (noise[HIGH_W+LOW_W-1:0] & ~keep);
        end
        queue_request(wft_pkg::CMD_ADD, word[LOW_W-1:0], word[HIGH_W+LOW_W-1:LOW_W], len,
                      $urandom_range(0, 29) == 0);
      end
    end
    pending_requests[RANDOM_REQS / 2].drain = 1'b1;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || n_accepted != n_issued ||
           expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("PASS word_frequency_table");
    end else begin
      $display("FAIL word_frequency_table");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/wft_pkg.sv
rtl/wft_cell.sv
rtl/word_frequency_table.sv
sim/word_frequency_table_tb.sv
